// ----- hdl/skvt_pkg.sv -----
// Shared types and constants for the sorted key/value table.
`timescale 1ns / 1ps

package skvt_pkg;

    // Field widths of the request and result words
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int TOTAL_BITS = 7;

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [VALUE_BITS-1:0]      t_value;
    typedef logic [TOTAL_BITS-1:0]      t_total;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_DUP     = 2'd1,
        STS_MISSING = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } t_state;

    // Request and result payloads
    typedef struct packed {
        t_action action;
        t_key    key;
        t_value  value;
    } t_req;

    typedef struct packed {
        t_status status;
        t_value  found_value;
        t_total  entry_total;
    } t_rsp;

    // Per-cell compare flags: stored key below probe key, stored key equal
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_flags;

    // Chain-wide shift commands
    typedef struct packed {
        logic ins;
        logic del;
    } t_chain_ctl;

endpackage

// ----- hdl/sorted_key_value_table.sv -----
// Top level of the sorted key/value table: request control and cell chain.
`timescale 1ns / 1ps

// Sorted key/value table holding up to CAPACITY pairs in ascending signed
// key order with unique keys. Each request inserts, searches or removes one
// key and yields exactly one result carrying a status, the found value on a
// search hit, and the entry count after the operation. On a request's
// transfer every cell compares its key with the request key and registers
// its flags; in the update state the chain shifts one place where needed
// and the result is registered. A new request is taken only once the
// previous result is registered and the control is idle again, so no new
// request is accepted while one is in progress; the update waits while an
// earlier result has not been taken. No clearing pass is needed after reset.
module sorted_key_value_table #(
    parameter int CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  skvt_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output skvt_pkg::t_rsp  o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    skvt_pkg::t_state r_state;
    skvt_pkg::t_state n_state;

    skvt_pkg::t_action r_action;
    skvt_pkg::t_key    r_key;
    skvt_pkg::t_value  r_value;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    skvt_pkg::t_rsp    r_out;
    skvt_pkg::t_rsp    n_out;

    logic                 w_accept;
    logic                 w_upd_go;
    logic                 w_hit;
    logic                 w_full;
    skvt_pkg::t_value     w_found;
    skvt_pkg::t_chain_ctl w_ctl;

    skvt_pkg::t_key       w_cell_key   [CAPACITY];
    skvt_pkg::t_value     w_cell_value [CAPACITY];
    skvt_pkg::t_cmp_flags w_flags      [CAPACITY];
    logic [CAPACITY-1:0]  w_lt_vec;
    logic [CAPACITY-1:0]  w_eq_vec;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skvt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = skvt_pkg::ST_UPDATE;
            end
            skvt_pkg::ST_UPDATE: begin
                if (w_upd_go) n_state = skvt_pkg::ST_IDLE;
            end
            default: n_state = skvt_pkg::ST_IDLE;
        endcase
    end

    // State outputs: take requests when idle, update once the result slot frees
    always_comb begin
        o_in_ready = 1'b0;
        w_upd_go   = 1'b0;
        case (r_state)
            skvt_pkg::ST_IDLE:   o_in_ready = 1'b1;
            skvt_pkg::ST_UPDATE: w_upd_go   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_upd_go   = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Gather hit and found value over the chain
    always_comb begin
        w_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt_vec[i] = w_flags[i].lt;
            w_eq_vec[i] = w_flags[i].eq;
            if (w_flags[i].eq) w_found = w_found | w_cell_value[i];
        end
    end

    assign w_hit  = |w_eq_vec;
    assign w_full = r_count >= CW'(CAPACITY);

    // Decide the chain command, new count and result
    always_comb begin
        w_ctl       = '0;
        n_count     = r_count;
        n_out       = r_out;
        n_out.status      = skvt_pkg::STS_OK;
        n_out.found_value = '0;
        case (r_action)
            skvt_pkg::ACT_INSERT: begin
                if (w_hit) begin
                    n_out.status = skvt_pkg::STS_DUP;
                end else if (w_full) begin
                    n_out.status = skvt_pkg::STS_FULL;
                end else begin
                    w_ctl.ins = w_upd_go;
                    n_count   = r_count + CW'(1);
                end
            end
            skvt_pkg::ACT_SEARCH: begin
                if (w_hit) n_out.found_value = w_found;
                else       n_out.status      = skvt_pkg::STS_MISSING;
            end
            skvt_pkg::ACT_REMOVE: begin
                if (w_hit) begin
                    w_ctl.del = w_upd_go;
                    n_count   = r_count - CW'(1);
                end else begin
                    n_out.status = skvt_pkg::STS_MISSING;
                end
            end
            default: n_out.status = skvt_pkg::STS_OK;
        endcase
        n_out.entry_total = skvt_pkg::TOTAL_BITS'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in.action;
            r_key    <= i_in.key;
            r_value  <= i_in.value;
        end
        if (w_upd_go) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] INDEX = CW'(g);
        logic             w_left_lt;
        skvt_pkg::t_key   w_left_key;
        skvt_pkg::t_value w_left_value;
        skvt_pkg::t_key   w_right_key;
        skvt_pkg::t_value w_right_value;

        if (g == 0) begin : g_first
            assign w_left_lt    = 1'b1;
            assign w_left_key   = r_key;
            assign w_left_value = r_value;
        end else begin : g_mid
            assign w_left_lt    = w_flags[g-1].lt;
            assign w_left_key   = w_cell_key[g-1];
            assign w_left_value = w_cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key   = '0;
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_key   = w_cell_key[g+1];
            assign w_right_value = w_cell_value[g+1];
        end

        skvt_cell u_cell (
            .i_clk         (i_clk),
            .i_cmp_en      (w_accept),
            .i_occupied    (INDEX < r_count),
            .i_probe_key   (i_in.key),
            .i_ctl         (w_ctl),
            .i_left_lt     (w_left_lt),
            .i_left_key    (w_left_key),
            .i_left_value  (w_left_value),
            .i_right_key   (w_right_key),
            .i_right_value (w_right_value),
            .i_new_key     (r_key),
            .i_new_value   (r_value),
            .o_key         (w_cell_key[g]),
            .o_value       (w_cell_value[g]),
            .o_flags       (w_flags[g])
        );
    end

    // Count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Unique keys: at most one cell matches
    a_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::ST_UPDATE) |-> $onehot0(w_eq_vec))
        else $error("more than one cell matches the key");

    // Sorted order: the below-key flags form a prefix of the chain
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::ST_UPDATE) |-> ((w_lt_vec & (w_lt_vec + 1'b1)) == '0))
        else $error("below-key flags are not a prefix");

    // Count moves only on an update
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_upd_go |=> $stable(r_count))
        else $error("entry count changed outside an update");

endmodule

// ----- hdl/skvt_cell.sv -----
// One slot of the sorted chain: holds a pair, compares it and shifts it.
`timescale 1ns / 1ps

module skvt_cell (
    input  logic                i_clk,
    input  logic                i_cmp_en,
    input  logic                i_occupied,
    input  skvt_pkg::t_key      i_probe_key,
    input  skvt_pkg::t_chain_ctl i_ctl,
    input  logic                i_left_lt,
    input  skvt_pkg::t_key      i_left_key,
    input  skvt_pkg::t_value    i_left_value,
    input  skvt_pkg::t_key      i_right_key,
    input  skvt_pkg::t_value    i_right_value,
    input  skvt_pkg::t_key      i_new_key,
    input  skvt_pkg::t_value    i_new_value,
    output skvt_pkg::t_key      o_key,
    output skvt_pkg::t_value    o_value,
    output skvt_pkg::t_cmp_flags o_flags
);

    skvt_pkg::t_key       r_key;
    skvt_pkg::t_value     r_value;
    skvt_pkg::t_cmp_flags r_flags;
    skvt_pkg::t_key       n_key;
    skvt_pkg::t_value     n_value;
    skvt_pkg::t_cmp_flags n_flags;

    // Compare the stored key against the probe key on a request transfer
    always_comb begin
        n_flags = r_flags;
        if (i_cmp_en) begin
            n_flags.lt = i_occupied && (r_key < i_probe_key);
            n_flags.eq = i_occupied && (r_key == i_probe_key);
        end
    end

    // Shift: slots at or above the insert point move up, those at or
    // above the removed slot pull from the right neighbour
    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.ins && !r_flags.lt) begin
            if (i_left_lt) begin
                n_key   = i_new_key;
                n_value = i_new_value;
            end else begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end
        end else if (i_ctl.del && !r_flags.lt) begin
            n_key   = i_right_key;
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_flags <= n_flags;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_flags = r_flags;

endmodule

// ----- sim/sorted_key_value_table_tb.sv -----
// Self-checking testbench for the sorted key/value table.
`timescale 1ns / 1ps

module sorted_key_value_table_tb;

    localparam int             TABLE_DEPTH = 64;
    localparam int             CYCLE_LIMIT = 200000;
    localparam skvt_pkg::t_key KEY_MIN     = {1'b1, {(skvt_pkg::KEY_BITS-1){1'b0}}};
    localparam skvt_pkg::t_key KEY_MAX     = {1'b0, {(skvt_pkg::KEY_BITS-1){1'b1}}};

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    skvt_pkg::t_req i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    skvt_pkg::t_rsp o_out;

    // Mirror of the table contents, kept in ascending signed key order
    skvt_pkg::t_key   tbl_keys [TABLE_DEPTH];
    skvt_pkg::t_value tbl_values [TABLE_DEPTH];
    int               tbl_count = 0;

    skvt_pkg::t_rsp pending_rsp [$];
    int             error_count = 0;
    int             cycle_count = 0;
    bit             send_steady = 1'b0;
    bit             recv_steady = 1'b0;

    sorted_key_value_table #(
        .CAPACITY (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one request to the mirror table and return the result it yields
    function automatic skvt_pkg::t_rsp apply_request(skvt_pkg::t_req req);
        skvt_pkg::t_rsp rsp;
        int             pos;
        bit             hit;
        pos = 0;
        while (pos < tbl_count && $signed(tbl_keys[pos]) < $signed(req.key))
            pos++;
        hit = (pos < tbl_count) && (tbl_keys[pos] == req.key);
        rsp.status      = skvt_pkg::STS_OK;
        rsp.found_value = '0;
        case (req.action)
            skvt_pkg::ACT_INSERT: begin
                if (hit) begin
                    rsp.status = skvt_pkg::STS_DUP;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    rsp.status = skvt_pkg::STS_FULL;
                end else begin
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_keys[i]   = tbl_keys[i-1];
                        tbl_values[i] = tbl_values[i-1];
                    end
                    tbl_keys[pos]   = req.key;
                    tbl_values[pos] = req.value;
                    tbl_count++;
                end
            end
            skvt_pkg::ACT_SEARCH: begin
                if (hit)
                    rsp.found_value = tbl_values[pos];
                else
                    rsp.status = skvt_pkg::STS_MISSING;
            end
            skvt_pkg::ACT_REMOVE: begin
                if (hit) begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_keys[i]   = tbl_keys[i+1];
                        tbl_values[i] = tbl_values[i+1];
                    end
                    tbl_count--;
                end else begin
                    rsp.status = skvt_pkg::STS_MISSING;
                end
            end
            default: ;
        endcase
        rsp.entry_total = skvt_pkg::t_total'(tbl_count);
        return rsp;
    endfunction

    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // Half the draws pick a held key or one above it, else extremes, keys near zero or anything
    function automatic skvt_pkg::t_key pick_key();
        skvt_pkg::t_key k;
        case ($urandom_range(0, 7))
            0, 1, 2: k = (tbl_count > 0) ? tbl_keys[$urandom_range(0, tbl_count - 1)]
                                         : skvt_pkg::t_key'($urandom);
            3:       k = (tbl_count > 0) ? tbl_keys[$urandom_range(0, tbl_count - 1)] + 1
                                         : skvt_pkg::t_key'($urandom);
            4:       k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            5:       k = skvt_pkg::t_key'($signed($urandom_range(0, 15)) - 8);
            default: k = skvt_pkg::t_key'($urandom);
        endcase
        return k;
    endfunction

    // Send one request; returns at the falling edge after its transfer
    task automatic send_request(skvt_pkg::t_action act, skvt_pkg::t_key key,
                                skvt_pkg::t_value value);
        skvt_pkg::t_req req;
        int             gap;
        req.action = act;
        req.key    = key;
        req.value  = value;
        gap = draw_wait(send_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rsp.push_back(apply_request(req));
        @(negedge i_clk);
    endtask

    // Result side: hold ready low for a random wait before each transfer, none when steady
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(recv_steady);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        skvt_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_out.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status, o_out.status);
                    error_count++;
                end
                if (o_out.found_value !== exp_rsp.found_value) begin
                    $error("found_value: expected %h, actual %h",
                           exp_rsp.found_value, o_out.found_value);
                    error_count++;
                end
                if (o_out.entry_total !== exp_rsp.entry_total) begin
                    $error("entry_total: expected %0d, actual %0d",
                           exp_rsp.entry_total, o_out.entry_total);
                    error_count++;
                end
            end
        end
    end

    // Empty table, key and value extremes, duplicates, misses, unused action
    task automatic test_directed_cases();
        send_request(skvt_pkg::ACT_SEARCH, 5, 32'h1111_1111);
        send_request(skvt_pkg::ACT_REMOVE, 5, '0);
        send_request(skvt_pkg::ACT_NONE, KEY_MAX, '1);
        send_request(skvt_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF);
        send_request(skvt_pkg::ACT_INSERT, KEY_MIN, 32'h0000_0000);
        send_request(skvt_pkg::ACT_INSERT, KEY_MAX, 32'hA5A5_A5A5);
        send_request(skvt_pkg::ACT_INSERT, -1, 32'h5A5A_5A5A);
        send_request(skvt_pkg::ACT_INSERT, 1, 32'h0000_0001);
        send_request(skvt_pkg::ACT_INSERT, 0, 32'h1234_5678);
        send_request(skvt_pkg::ACT_SEARCH, KEY_MIN, '1);
        send_request(skvt_pkg::ACT_SEARCH, KEY_MAX, '0);
        send_request(skvt_pkg::ACT_SEARCH, -1, '0);
        send_request(skvt_pkg::ACT_SEARCH, 0, '0);
        send_request(skvt_pkg::ACT_SEARCH, 2, '0);
        send_request(skvt_pkg::ACT_NONE, 0, 32'hDEAD_BEEF);
        send_request(skvt_pkg::ACT_REMOVE, -1, '1);
        send_request(skvt_pkg::ACT_SEARCH, -1, '0);
        send_request(skvt_pkg::ACT_REMOVE, KEY_MIN, '0);
        send_request(skvt_pkg::ACT_REMOVE, KEY_MAX, '0);
        send_request(skvt_pkg::ACT_REMOVE, KEY_MAX, '0);
        send_request(skvt_pkg::ACT_INSERT, -1, 32'h8765_4321);
        send_request(skvt_pkg::ACT_SEARCH, -1, '0);
        send_request(skvt_pkg::ACT_REMOVE, 0, '0);
        send_request(skvt_pkg::ACT_REMOVE, 1, '0);
        send_request(skvt_pkg::ACT_REMOVE, -1, '0);
    endtask

    // Fill to capacity, then refuse a new key and report a held one as duplicate
    task automatic test_fill_to_full();
        skvt_pkg::t_key held;
        send_request(skvt_pkg::ACT_INSERT, KEY_MIN, $urandom);
        send_request(skvt_pkg::ACT_INSERT, KEY_MAX, $urandom);
        while (tbl_count < TABLE_DEPTH)
            send_request(skvt_pkg::ACT_INSERT, pick_key(), $urandom);
        held = tbl_keys[$urandom_range(0, TABLE_DEPTH - 1)];
        send_request(skvt_pkg::ACT_INSERT, skvt_pkg::t_key'($urandom), $urandom);
        send_request(skvt_pkg::ACT_INSERT, held, $urandom);
        send_request(skvt_pkg::ACT_SEARCH, held, '0);
        send_request(skvt_pkg::ACT_SEARCH, KEY_MIN, '0);
        send_request(skvt_pkg::ACT_SEARCH, KEY_MAX, '0);
        send_request(skvt_pkg::ACT_NONE, held, $urandom);
    endtask

    // Remove entries in random order, with some searches between, until the table is empty
    task automatic test_drain_to_empty();
        while (tbl_count > 0) begin
            if ($urandom_range(0, 4) == 0)
                send_request(skvt_pkg::ACT_SEARCH, pick_key(), $urandom);
            send_request(skvt_pkg::ACT_REMOVE, pick_key(), $urandom);
        end
    endtask

    // Mixed traffic in phases that lean towards growth or shrinkage
    task automatic test_random_mix();
        int                ins_weight;
        int                roll;
        skvt_pkg::t_action act;
        skvt_pkg::t_value  value;
        for (int phase = 0; phase < 5; phase++) begin
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       ins_weight = 20;
                1:       ins_weight = 50;
                default: ins_weight = 85;
            endcase
            for (int n = 0; n < 50; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    act = skvt_pkg::ACT_NONE;
                else if (roll < 3 + ins_weight)
                    act = skvt_pkg::ACT_INSERT;
                else if (roll % 2 == 0)
                    act = skvt_pkg::ACT_SEARCH;
                else
                    act = skvt_pkg::ACT_REMOVE;
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom;
                endcase
                send_request(act, pick_key(), value);
            end
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_fill_to_full();
        test_drain_to_empty();
        test_random_mix();
        i_in_valid <= 1'b0;

        // Wait out every outstanding result, then idle before reporting
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
